FILE: rtl/arisel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arisel_pkg: shared types and constants
// Register map, reset values, step codes and the structs exchanged between
// the configuration block and the repeat core.
// ----------------------------------------------------------------------------
package arisel_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_SLOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MEDIUM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FAST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE    = 3'd7;

    // Register reset values
    localparam logic [7:0] WAIT_SLOW_RST      = 8'd10;
    localparam logic [7:0] WAIT_MEDIUM_RST    = 8'd5;
    localparam logic [7:0] WAIT_FAST_RST      = 8'd2;
    localparam logic [7:0] SPEEDUP_FIRST_RST  = 8'd2;
    localparam logic [7:0] SPEEDUP_SECOND_RST = 8'd2;
    localparam logic [8:0] ITEM_COUNT_RST     = 9'd8;
    localparam logic [7:0] START_POSITION_RST = 8'd0;
    localparam logic       WRAP_ENABLE_RST    = 1'b0;

    // Speed levels
    localparam logic [1:0] LEVEL_SLOW   = 2'd0;
    localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [1:0] LEVEL_FAST   = 2'd2;

    // Step codes
    localparam logic signed [1:0] STEP_NONE = 2'sb00;
    localparam logic signed [1:0] STEP_UP   = 2'sb01;
    localparam logic signed [1:0] STEP_DOWN = 2'sb11;

    // Repeat counter saturation value
    localparam logic [15:0] REPEAT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] wait_slow;
        logic [7:0] wait_medium;
        logic [7:0] wait_fast;
        logic [7:0] speedup_first;
        logic [7:0] speedup_second;
        logic [8:0] item_count;
        logic       wrap_enable;
    } cfg_t;

    // Selection load request from a start_position write
    typedef struct packed {
        logic       en;
        logic [7:0] value;
    } sel_load_t;

endpackage
`default_nettype wire

FILE: rtl/arisel_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arisel_cfg_regs: configuration register file
// Holds the write-only settings and raises a selection load request when
// start_position is written.
// ----------------------------------------------------------------------------
module arisel_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [arisel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arisel_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output arisel_pkg::cfg_t                       cfg,
    output arisel_pkg::sel_load_t                  sel_load
);
    import arisel_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the register image
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WAIT_SLOW:      cfg_next.wait_slow      = cfg_wdata[7:0];
                CFG_WAIT_MEDIUM:    cfg_next.wait_medium    = cfg_wdata[7:0];
                CFG_WAIT_FAST:      cfg_next.wait_fast      = cfg_wdata[7:0];
                CFG_SPEEDUP_FIRST:  cfg_next.speedup_first  = cfg_wdata[7:0];
                CFG_SPEEDUP_SECOND: cfg_next.speedup_second = cfg_wdata[7:0];
                CFG_ITEM_COUNT:     cfg_next.item_count     = cfg_wdata[8:0];
                CFG_WRAP_ENABLE:    cfg_next.wrap_enable    = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_slow      <= WAIT_SLOW_RST;
            cfg_reg.wait_medium    <= WAIT_MEDIUM_RST;
            cfg_reg.wait_fast      <= WAIT_FAST_RST;
            cfg_reg.speedup_first  <= SPEEDUP_FIRST_RST;
            cfg_reg.speedup_second <= SPEEDUP_SECOND_RST;
            cfg_reg.item_count     <= ITEM_COUNT_RST;
            cfg_reg.wrap_enable    <= WRAP_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // start_position only matters as a load of the selection
    assign sel_load.en    = cfg_we && (cfg_index == CFG_START_POSITION);
    assign sel_load.value = cfg_wdata[7:0];

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/arisel_repeat_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arisel_repeat_core: auto-repeat state and next-state logic
// Holds selection, speed level, repeat counts and the frame counter, and
// works out the move for one frame in a single pass.
// ----------------------------------------------------------------------------
module arisel_repeat_core #(
    parameter int MAX_ITEMS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic              press_up,
    input  wire logic              press_down,
    input  arisel_pkg::cfg_t       cfg,
    input  arisel_pkg::sel_load_t  sel_load,
    output logic signed [1:0]      step_taken,
    output logic [7:0]             position
);
    import arisel_pkg::*;

    localparam int ClogMax = $clog2(MAX_ITEMS + 1);
    localparam int ExtW    = (ClogMax > 9) ? ClogMax : 9;
    localparam logic [ExtW-1:0] MaxItemsExt = ExtW'(MAX_ITEMS);
    localparam logic [ExtW-1:0] LastCap     = ExtW'(255);

    logic [7:0]  selection_reg, selection_next;
    logic [1:0]  level_reg, level_next;
    logic [15:0] up_rep_reg, up_rep_next;
    logic [15:0] dn_rep_reg, dn_rep_next;
    logic [7:0]  frame_wait_reg, frame_wait_next;

    logic [ExtW-1:0]   count_ext;
    logic [ExtW-1:0]   count_lim;
    logic [ExtW-1:0]   last_full;
    logic [7:0]        last_idx;
    logic              go_up, go_down, active;
    logic [15:0]       own_rep, own_inc;
    logic [7:0]        level_wait;
    logic [7:0]        threshold;
    logic [1:0]        base_level;
    logic              move;
    logic signed [1:0] step_next;

    // Last valid index: count forced to at least one, capped by MAX_ITEMS and 256
    always_comb
    begin
        count_ext = ExtW'(cfg.item_count);
        if (cfg.item_count == 9'd0)
        begin
            count_ext = ExtW'(1);
        end
        count_lim = (count_ext > MaxItemsExt) ? MaxItemsExt : count_ext;
        last_full = count_lim - ExtW'(1);
        last_idx  = (last_full > LastCap) ? 8'hFF : last_full[7:0];
    end

    // Repeat timing, level update and index move
    always_comb
    begin
        go_up   = press_up;
        go_down = !press_up && press_down;
        active  = go_up || go_down;
        own_rep = go_up ? up_rep_reg : dn_rep_reg;

        case (level_reg)
            LEVEL_SLOW:   level_wait = cfg.wait_slow;
            LEVEL_MEDIUM: level_wait = cfg.wait_medium;
            default:      level_wait = cfg.wait_fast;
        endcase

        move       = active && ((own_rep == 16'd0) || (frame_wait_reg == level_wait));
        base_level = (own_rep == 16'd0) ? LEVEL_SLOW : level_reg;
        own_inc    = (own_rep != REPEAT_MAX) ? own_rep + 16'd1 : own_rep;
        threshold  = (base_level == LEVEL_SLOW) ? cfg.speedup_first : cfg.speedup_second;

        selection_next  = selection_reg;
        level_next      = level_reg;
        up_rep_next     = up_rep_reg;
        dn_rep_next     = dn_rep_reg;
        frame_wait_next = frame_wait_reg;
        step_next       = STEP_NONE;

        if (!active)
        begin
            // Both released: clear all counters
            level_next      = LEVEL_SLOW;
            up_rep_next     = 16'd0;
            dn_rep_next     = 16'd0;
            frame_wait_next = 8'd0;
        end
        else if (!move)
        begin
            frame_wait_next = frame_wait_reg + 8'd1;
        end
        else
        begin
            frame_wait_next = 8'd0;
            level_next      = base_level;
            if ((base_level != LEVEL_FAST) && (own_inc == {8'd0, threshold}))
            begin
                level_next = base_level + 2'd1;
            end
            if (go_up)
            begin
                up_rep_next = own_inc;
                dn_rep_next = 16'd0;
                if (selection_reg < last_idx)
                begin
                    selection_next = selection_reg + 8'd1;
                    step_next      = STEP_UP;
                end
                else if (cfg.wrap_enable)
                begin
                    selection_next = 8'd0;
                    step_next      = STEP_UP;
                end
            end
            else
            begin
                dn_rep_next = own_inc;
                up_rep_next = 16'd0;
                if (selection_reg != 8'd0)
                begin
                    selection_next = selection_reg - 8'd1;
                    step_next      = STEP_DOWN;
                end
                else if (cfg.wrap_enable)
                begin
                    selection_next = last_idx;
                    step_next      = STEP_DOWN;
                end
            end
        end
    end

    // State registers; a start_position write reloads the selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selection_reg  <= START_POSITION_RST;
            level_reg      <= LEVEL_SLOW;
            up_rep_reg     <= 16'd0;
            dn_rep_reg     <= 16'd0;
            frame_wait_reg <= 8'd0;
        end
        else if (sel_load.en)
        begin
            selection_reg <= sel_load.value;
        end
        else if (step_en)
        begin
            selection_reg  <= selection_next;
            level_reg      <= level_next;
            up_rep_reg     <= up_rep_next;
            dn_rep_reg     <= dn_rep_next;
            frame_wait_reg <= frame_wait_next;
        end
    end

    assign step_taken = step_next;
    assign position   = selection_next;

    // Only one direction ever holds a repeat count
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (up_rep_reg == 16'd0) || (dn_rep_reg == 16'd0))
        else $error("both repeat counts nonzero");

    // Speed level never passes the fast level
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg != 2'd3)
        else $error("speed level out of range");

    // A move frame restarts the frame counter
    a_move_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && move && !sel_load.en) |=> (frame_wait_reg == 8'd0))
        else $error("frame counter not cleared after a move");

    // Release of both buttons clears counters and level
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !press_up && !press_down && !sel_load.en) |=>
        (up_rep_reg == 16'd0) && (dn_rep_reg == 16'd0) && (level_reg == LEVEL_SLOW))
        else $error("counters not cleared on release");

endmodule
`default_nettype wire

FILE: rtl/auto_repeat_index_selector_core.sv
`default_nettype none
// A frame passes the input register, then the output register once it is free.
// Throughput: one frame per cycle; the input register, the single-pass update
// and the output register all advance together each cycle the output is free.
// Reset (rst_n low, asynchronous): registers take their documented defaults,
// selection loads 0, counters and speed level clear, both pipeline stages empty.
// ----------------------------------------------------------------------------
// auto_repeat_index_selector_core: accelerating auto-repeat index selector
// Input register, repeat core and output register with valid/stall handshake
// on both channels, plus the configuration register file.
// ----------------------------------------------------------------------------
module auto_repeat_index_selector_core #(
    parameter int MAX_ITEMS = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              press_up,
    input  wire logic                              press_down,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [1:0]                      step_taken,
    output logic [7:0]                             position,
    input  wire logic                              cfg_we,
    input  wire logic [arisel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arisel_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import arisel_pkg::*;

    cfg_t      cfg;
    sel_load_t sel_load;

    logic              in_valid_reg;
    logic              up_reg, down_reg;
    logic              out_valid_reg;
    logic signed [1:0] step_reg;
    logic [7:0]        position_reg;
    logic              out_free;
    logic              step_en;
    logic              in_xfer;
    logic signed [1:0] core_step;
    logic [7:0]        core_position;

    // Handshake: the core advances when a frame waits and the output can load
    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    arisel_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .sel_load  (sel_load)
    );

    arisel_repeat_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .press_up   (up_reg),
        .press_down (down_reg),
        .cfg        (cfg),
        .sel_load   (sel_load),
        .step_taken (core_step),
        .position   (core_position)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            up_reg   <= press_up;
            down_reg <= press_down;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            step_reg     <= core_step;
            position_reg <= core_position;
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_taken = step_reg;
    assign position   = position_reg;

    // A held result keeps its place while the input stage fills behind it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

    // The input stage drains only into a free output register
    a_drain_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input stage advanced into a stalled output");

    // Every advance of the core lands a result
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("advanced frame produced no result");

endmodule
`default_nettype wire
